FILE: src/pnd_pkg.sv
// Package for the prefix-code nibble decoder.
// Holds shared constants, the controller state type and the command/status structs.
// No dependencies.
package pnd_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TABLE_WORDS   = 4;
    localparam int ENTRY_BITS    = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN = 3'd4;

    localparam logic [15:0] LEN_RESET    = 16'h0064;
    localparam logic [4:0]  BYTE_BITS    = 5'd8;
    localparam logic [1:0]  MAX_RESULTS  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;    // latch request byte, clear state on restart
        logic load;      // shift the latched byte into the bit buffer
        logic consume;   // consume matched code, maybe emit a byte
        logic emit_err;  // emit error result and halt
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic halted;
        logic need_load;  // 8 or fewer bits buffered
        logic hit;        // some table entry matched
        logic phase;      // high nibble already held
        logic slot_free;  // output register can take a result this cycle
    } t_status;

endpackage

FILE: src/pnd_ctrl.sv
// Controller for the prefix-code nibble decoder; uses pnd_pkg.
// Sequences one decode step per cycle per request, bar output stalls.
module pnd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pnd_pkg::t_status  i_status,
    output logic              o_busy,
    output pnd_pkg::t_cmd     o_cmd
);

    pnd_pkg::t_state r_state, n_state;
    logic            r_taken, n_taken;
    logic [1:0]      r_nres, n_nres;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pnd_pkg::ST_IDLE;
            r_taken <= 1'b0;
            r_nres  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_taken <= n_taken;
            r_nres  <= n_nres;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_taken = r_taken;
        n_nres  = r_nres;
        o_cmd   = '0;
        case (r_state)
            pnd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_taken      = 1'b0;
                    n_nres       = 2'd0;
                    n_state      = pnd_pkg::ST_RUN;
                end
            end
            pnd_pkg::ST_RUN: begin
                if (i_status.halted) begin
                    n_state = pnd_pkg::ST_IDLE;
                end else if (i_status.need_load) begin
                    // byte goes in once; a second need ends the request
                    if (r_taken) begin
                        n_state = pnd_pkg::ST_IDLE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_taken    = 1'b1;
                    end
                end else if (!i_status.hit) begin
                    if (r_nres < pnd_pkg::MAX_RESULTS) begin
                        if (i_status.slot_free) begin
                            o_cmd.emit_err = 1'b1;
                            n_state        = pnd_pkg::ST_IDLE;
                        end
                    end else begin
                        n_state = pnd_pkg::ST_IDLE;
                    end
                end else if (i_status.phase) begin
                    // completes a byte: limited to two results per request
                    if (r_nres == pnd_pkg::MAX_RESULTS) begin
                        n_state = pnd_pkg::ST_IDLE;
                    end else if (i_status.slot_free) begin
                        o_cmd.consume = 1'b1;
                        n_nres        = r_nres + 2'd1;
                    end
                end else begin
                    o_cmd.consume = 1'b1;
                end
            end
            default: begin
                n_state = pnd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != pnd_pkg::ST_IDLE);

endmodule

FILE: src/pnd_datapath.sv
// Datapath for the prefix-code nibble decoder: config registers, bit buffer,
// parallel table match, nibble packing and the output register. Uses pnd_pkg.
module pnd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pnd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pnd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_restart,
    input  pnd_pkg::t_cmd                   i_cmd,
    output pnd_pkg::t_status                o_status,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last,
    output logic                            o_error
);

    logic [pnd_pkg::CFG_DATA_W-1:0] r_table [pnd_pkg::TABLE_WORDS];
    logic [15:0] r_out_len;

    logic [7:0]  r_byte;
    logic [15:0] r_buf;
    logic [4:0]  r_bits;
    logic [3:0]  r_high;
    logic        r_phase;
    logic [15:0] r_out_count;
    logic        r_halted;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_last;
    logic        r_error;

    logic [pnd_pkg::ENTRY_BITS-1:0] w_entry [pnd_pkg::TABLE_ENTRIES];
    logic [pnd_pkg::TABLE_ENTRIES-1:0] w_hit_vec;
    logic        w_hit;
    logic [3:0]  w_len;
    logic [3:0]  w_sym;
    logic [15:0] w_next_count;
    logic        w_last;
    logic        w_slot_free;

    // Table entries and per-entry match
    for (genvar g = 0; g < pnd_pkg::TABLE_ENTRIES; g++) begin : g_entry
        logic [3:0] len;
        logic [7:0] code;
        logic [7:0] top;
        assign w_entry[g] = r_table[g / 4][(g % 4) * pnd_pkg::ENTRY_BITS +: pnd_pkg::ENTRY_BITS];
        assign len  = w_entry[g][3:0];
        assign code = w_entry[g][15:8];
        assign top  = r_buf[15:8] >> (4'd8 - len);
        assign w_hit_vec[g] = (len != 4'd0) && (len <= 4'd8)
                              && ((code >> len) == 8'd0) && (code == top);
    end

    // Lowest-numbered matching entry wins
    always_comb begin
        w_hit = 1'b0;
        w_len = 4'd0;
        w_sym = 4'd0;
        for (int i = pnd_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (w_hit_vec[i]) begin
                w_hit = 1'b1;
                w_len = w_entry[i][3:0];
                w_sym = w_entry[i][7:4];
            end
        end
    end

    assign w_next_count = r_out_count + 16'd1;
    assign w_last       = (w_next_count >= r_out_len);
    assign w_slot_free  = !r_out_valid || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pnd_pkg::TABLE_WORDS; i++) begin
                r_table[i] <= '0;
            end
            r_out_len <= pnd_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pnd_pkg::REG_TABLE_0: r_table[0] <= i_cfg_data;
                pnd_pkg::REG_TABLE_1: r_table[1] <= i_cfg_data;
                pnd_pkg::REG_TABLE_2: r_table[2] <= i_cfg_data;
                pnd_pkg::REG_TABLE_3: r_table[3] <= i_cfg_data;
                pnd_pkg::REG_OUT_LEN: r_out_len  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte      <= 8'd0;
            r_buf       <= 16'd0;
            r_bits      <= 5'd0;
            r_high      <= 4'd0;
            r_phase     <= 1'b0;
            r_out_count <= 16'd0;
            r_halted    <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_byte <= i_in_byte;
                if (i_restart) begin
                    r_buf       <= 16'd0;
                    r_bits      <= 5'd0;
                    r_high      <= 4'd0;
                    r_phase     <= 1'b0;
                    r_out_count <= 16'd0;
                    r_halted    <= 1'b0;
                end
            end
            if (i_cmd.load) begin
                r_buf  <= r_buf | ({r_byte, 8'd0} >> r_bits);
                r_bits <= r_bits + pnd_pkg::BYTE_BITS;
            end
            if (i_cmd.consume) begin
                r_buf   <= r_buf << w_len;
                r_bits  <= r_bits - {1'b0, w_len};
                r_phase <= !r_phase;
                if (!r_phase) begin
                    r_high <= w_sym;
                end else begin
                    r_out_count <= w_next_count;
                    if (w_last) begin
                        r_halted <= 1'b1;
                    end
                end
            end
            if (i_cmd.emit_err) begin
                r_halted <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_byte  <= 8'd0;
            r_last      <= 1'b0;
            r_error     <= 1'b0;
        end else begin
            if (i_cmd.consume && r_phase) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= {r_high, w_sym};
                r_last      <= w_last;
                r_error     <= 1'b0;
            end else if (i_cmd.emit_err) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= 8'd0;
                r_last      <= 1'b1;
                r_error     <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.halted    = r_halted;
    assign o_status.need_load = (r_bits <= pnd_pkg::BYTE_BITS);
    assign o_status.hit       = w_hit;
    assign o_status.phase     = r_phase;
    assign o_status.slot_free = w_slot_free;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;
    assign o_error     = r_error;

endmodule

FILE: src/prefix_code_nibble_decoder.sv
// Top level of the prefix-code nibble decoder.
// Joins pnd_ctrl and pnd_datapath; uses pnd_pkg.
//
// Usage:
//  - Input channel: i_in_valid / o_in_stall carries i_in_byte (compressed bits,
//    MSB first) and i_restart (clears buffer, counters and halt first).
//  - Output channel: o_out_valid / i_out_stall carries o_out_byte (two symbols,
//    first in high nibble), o_last and o_error. Each request gives 0 to 2 results.
//  - Config: i_cfg_we writes i_cfg_data to register i_cfg_index (0-3 code table
//    words, 4 output length). Write only while the block is idle.
//  - A request is accepted and then runs one decode step per cycle, bar output
//    stalls: the byte load, a step per symbol (a table lookup each) and a final
//    step to finish. A request decodes at most five symbols.
//  - A result appears in the output register the cycle after its step, so the
//    first result of a request follows the accept and the step that made it.
//  - If the receiver stalls, the result holds and the decode step that needs
//    the output register waits; the next request is held off meanwhile.
//  - Reset (synchronous, active low) clears all state, the code table to zero
//    and the output length to 100; the input stalls while reset is held.
module prefix_code_nibble_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pnd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pnd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last,
    output logic                            o_error
);

    pnd_pkg::t_cmd    w_cmd;
    pnd_pkg::t_status w_status;
    logic             w_busy;

    // Step sequencer
    pnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_busy     (w_busy),
        .o_cmd      (w_cmd)
    );

    // Buffer, table match and output register
    pnd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (i_in_byte),
        .i_restart   (i_restart),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    assign o_in_stall = w_busy || !i_rst_n;

endmodule

FILE: bench/prefix_code_nibble_decoder_test.sv
// Self-checking bench for prefix_code_nibble_decoder: directed and random code tables,
// random byte streams, random idling on both channels. Depends on pnd_pkg and the RTL.
`timescale 1ns / 100ps

module prefix_code_nibble_decoder_test;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int RANDOM_REQUESTS = 1125;

    // One decoded output byte as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_out_byte;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [pnd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [pnd_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_stall;
    logic [7:0]                     i_in_byte;
    logic                           i_restart;
    logic                           o_out_valid;
    logic                           i_out_stall;
    logic [7:0]                     o_out_byte;
    logic                           o_last;
    logic                           o_error;

    prefix_code_nibble_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    always #6 i_clk = ~i_clk;

    // Decoder shadow: code table, stop length and stream state
    logic [pnd_pkg::CFG_DATA_W-1:0] code_words [pnd_pkg::TABLE_WORDS];
    logic [15:0]           stop_len;
    logic [15:0]           bit_buf;
    logic [4:0]            bit_cnt;
    logic [3:0]            held_sym;
    logic                  sym_phase;
    logic [15:0]           bytes_out;
    logic                  stopped;

    // Entries to load on the next configuration pass
    logic [15:0] code_plan [pnd_pkg::TABLE_ENTRIES];

    t_out_byte predicted_out [$];

    bit no_gaps;
    int fail_count;
    int cycle_count;
    int requests_sent;
    int requests_decoded;
    int results_seen;
    int error_results;
    int last_results;
    int tables_tried;

    function automatic void clear_decoder();
        bit_buf   = '0;
        bit_cnt   = '0;
        held_sym  = '0;
        sym_phase = 1'b0;
        bytes_out = '0;
        stopped   = 1'b0;
    endfunction

    // Lowest-numbered well-formed entry whose code equals the top bits of the buffer
    function automatic int match_entry();
        logic [15:0] e;
        logic [7:0]  top;
        int          len;
        for (int i = 0; i < pnd_pkg::TABLE_ENTRIES; i++) begin
            e   = code_words[i / 4][16 * (i % 4) +: 16];
            len = int'(e[3:0]);
            if (len >= 1 && len <= 8 && (e[15:8] >> len) == 0) begin
                top = 8'(bit_buf >> (16 - len));
                if (top == e[15:8])
                    return i;
            end
        end
        return -1;
    endfunction

    // Advance the shadow by one accepted request and queue the bytes it yields
    function automatic void decode_request(logic [7:0] din, logic rs);
        int          n;
        int          idx;
        int          len;
        bit          taken;
        logic [15:0] e;
        t_out_byte   r;
        n     = 0;
        taken = 1'b0;
        if (rs)
            clear_decoder();
        while (!stopped) begin
            if (bit_cnt <= pnd_pkg::BYTE_BITS) begin
                if (taken)
                    break;
                bit_buf = bit_buf | ({8'h00, din} << (pnd_pkg::BYTE_BITS - bit_cnt));
                bit_cnt = bit_cnt + pnd_pkg::BYTE_BITS;
                taken   = 1'b1;
                continue;
            end
            idx = match_entry();
            if (idx < 0) begin
                // no code fits: one error byte, pending nibble lost
                if (n < pnd_pkg::MAX_RESULTS) begin
                    r = '{data: 8'h00, last: 1'b1, err: 1'b1};
                    predicted_out.push_back(r);
                    n++;
                    stopped = 1'b1;
                end
                break;
            end
            // a third byte would be needed: leave the bits for the next request
            if (sym_phase && n >= pnd_pkg::MAX_RESULTS)
                break;
            e       = code_words[idx / 4][16 * (idx % 4) +: 16];
            len     = int'(e[3:0]);
            bit_buf = bit_buf << len;
            bit_cnt = bit_cnt - 5'(len);
            if (!sym_phase) begin
                held_sym  = e[7:4];
                sym_phase = 1'b1;
            end else begin
                sym_phase = 1'b0;
                bytes_out = bytes_out + 16'd1;
                r = '{data: {held_sym, e[7:4]}, last: (bytes_out >= stop_len), err: 1'b0};
                predicted_out.push_back(r);
                n++;
                if (r.last)
                    stopped = 1'b1;
            end
        end
    endfunction

    // Cycle count and run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver back-pressure: a fresh hold-off for every result
    always begin : out_stall_driver
        int hold;
        @(negedge i_clk);
        hold = no_gaps ? 0 : $urandom_range(14, 0);
        if (hold > 0) begin
            i_out_stall <= 1'b1;
            repeat (hold) @(negedge i_clk);
        end
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
    end

    // Compare every accepted result with the oldest predicted byte
    always @(posedge i_clk) begin : result_check
        t_out_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_error)
                error_results++;
            if (o_last)
                last_results++;
            if (predicted_out.size() == 0) begin
                $error("unexpected result: out_byte %02h last %0b error %0b",
                       o_out_byte, o_last, o_error);
                fail_count++;
            end else begin
                want = predicted_out.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h actual %02h", want.data, o_out_byte);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b actual %0b", want.last, o_last);
                    fail_count++;
                end
                if (o_error !== want.err) begin
                    $error("error: expected %0b actual %0b", want.err, o_error);
                    fail_count++;
                end
            end
        end
    end

    // Send one request; entered and left at a falling edge
    task automatic send_request(input logic [7:0] din, input logic rs);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(14, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= din;
        i_restart  <= rs;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
        if (!stopped || rs)
            requests_decoded++;
        decode_request(din, rs);
        @(negedge i_clk);
    endtask

    // Hold requests until every predicted byte is out and the block has gone quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (predicted_out.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the planned table and a stop length; only called while idle
    task automatic load_config(input logic [15:0] len);
        logic [pnd_pkg::CFG_DATA_W-1:0] words [pnd_pkg::TABLE_WORDS];
        logic [63:0]           pad;
        for (int w = 0; w < pnd_pkg::TABLE_WORDS; w++)
            words[w] = {code_plan[4 * w + 3], code_plan[4 * w + 2],
                        code_plan[4 * w + 1], code_plan[4 * w]};
        for (int w = 0; w < pnd_pkg::TABLE_WORDS; w++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= pnd_pkg::REG_TABLE_0 + w[pnd_pkg::CFG_IDX_W-1:0];
            i_cfg_data  <= words[w];
            @(negedge i_clk);
            code_words[w] = words[w];
        end
        // upper bits of the length word are don't-care
        pad = {$urandom, $urandom};
        i_cfg_index <= pnd_pkg::REG_OUT_LEN;
        i_cfg_data  <= {pad[63:16], len};
        @(negedge i_clk);
        stop_len = len;
        i_cfg_we <= 1'b0;
    endtask

    // Random complete prefix code by leaf splitting; optionally one leaf removed
    task automatic plan_random_code(input bit gap_in_code);
        logic [7:0] leaf_code [pnd_pkg::TABLE_ENTRIES];
        int         leaf_len [pnd_pkg::TABLE_ENTRIES];
        int         slot [pnd_pkg::TABLE_ENTRIES];
        int         count, target, j, tmp, drop;
        count        = 1;
        leaf_code[0] = '0;
        leaf_len[0]  = 0;
        target       = $urandom_range(pnd_pkg::TABLE_ENTRIES, 2);
        while (count < target) begin
            do j = $urandom_range(count - 1, 0); while (leaf_len[j] >= 8);
            leaf_code[count] = {leaf_code[j][6:0], 1'b1};
            leaf_len[count]  = leaf_len[j] + 1;
            leaf_code[j]     = {leaf_code[j][6:0], 1'b0};
            leaf_len[j]++;
            count++;
        end
        for (int i = 0; i < pnd_pkg::TABLE_ENTRIES; i++)
            slot[i] = i;
        for (int i = pnd_pkg::TABLE_ENTRIES - 1; i > 0; i--) begin
            j       = $urandom_range(i, 0);
            tmp     = slot[i];
            slot[i] = slot[j];
            slot[j] = tmp;
        end
        drop = gap_in_code ? $urandom_range(count - 1, 0) : -1;
        for (int i = 0; i < pnd_pkg::TABLE_ENTRIES; i++) begin
            if (i < count && i != drop)
                code_plan[slot[i]] = {leaf_code[i], 4'($urandom), 4'(leaf_len[i])};
            else if (gap_in_code)
                // filler that can never match, so the hole stays open
                code_plan[slot[i]] = {8'($urandom), 4'($urandom),
                                      ($urandom_range(1, 0) == 1) ? 4'd0
                                                                  : 4'($urandom_range(15, 9))};
            else
                code_plan[slot[i]] = 16'($urandom);
        end
    endtask

    // Table and length straight out of reset: nothing matches
    task automatic test_reset_table();
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(8'h12, 1'b0);  // halted: ignored
        send_request(8'hA5, 1'b1);
        send_request(8'h5A, 1'b0);
    endtask

    // Zero length, length above eight, all-ones entries
    task automatic test_invalid_entries();
        settle();
        for (int i = 0; i < pnd_pkg::TABLE_ENTRIES; i++)
            code_plan[i] = 16'hFFFF;
        code_plan[0] = {8'h00, 4'h5, 4'd0};
        code_plan[1] = {8'h00, 4'h6, 4'd9};
        load_config(16'd1);
        send_request(8'h00, 1'b1);
        send_request(8'h00, 1'b0);
    endtask

    // Fixed 4-bit codes, stop length at its maximum
    task automatic test_fixed_codes();
        settle();
        for (int i = 0; i < pnd_pkg::TABLE_ENTRIES; i++)
            code_plan[i] = {8'(i), 4'(15 - i), 4'd4};
        load_config(16'hFFFF);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'h5A, 1'b0);
        send_request(8'h0F, 1'b0);
    endtask

    // Stop length zero: the first byte is already the last
    task automatic test_zero_length();
        settle();
        load_config(16'd0);
        send_request(8'h12, 1'b1);
        send_request(8'h34, 1'b0);
    endtask

    // Lengths 1 to 8, malformed entries in front, duplicate code behind the winner
    task automatic test_mixed_lengths();
        settle();
        code_plan[0]  = {8'h00, 4'hE, 4'd0};  // length zero
        code_plan[1]  = {8'h00, 4'h1, 4'd9};  // longer than a byte
        code_plan[2]  = {8'h04, 4'h2, 4'd2};  // code wider than its length
        code_plan[3]  = {8'h00, 4'h4, 4'd1};
        code_plan[4]  = {8'h00, 4'h5, 4'd1};  // same code, lower priority
        code_plan[5]  = {8'h02, 4'h6, 4'd2};
        code_plan[6]  = {8'h06, 4'h7, 4'd3};
        code_plan[7]  = {8'h0E, 4'h8, 4'd4};
        code_plan[8]  = {8'h1E, 4'h9, 4'd5};
        code_plan[9]  = {8'h3E, 4'hA, 4'd6};
        code_plan[10] = {8'h7E, 4'hB, 4'd7};
        code_plan[11] = {8'hFE, 4'hC, 4'd8};
        code_plan[12] = {8'hFF, 4'hD, 4'd8};
        for (int i = 13; i < pnd_pkg::TABLE_ENTRIES; i++)
            code_plan[i] = 16'hFFFF;
        load_config(16'd3);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'hFE, 1'b0);
        send_request(8'h81, 1'b0);
        send_request(8'h42, 1'b1);
    endtask

    // 1-bit codes: more symbols than a request may emit, buffer overrun
    task automatic test_single_bit_codes();
        settle();
        for (int i = 0; i < pnd_pkg::TABLE_ENTRIES; i++)
            code_plan[i] = 16'h0000;
        code_plan[0] = {8'h00, 4'h3, 4'd1};
        code_plan[1] = {8'h01, 4'hC, 4'd1};
        load_config(16'hFFFF);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'h0F, 1'b0);
        send_request(8'hAA, 1'b0);
    endtask

    // Code with a hole: one stream decodes bytes, the next errors at its first lookup
    task automatic test_incomplete_code();
        settle();
        for (int i = 0; i < pnd_pkg::TABLE_ENTRIES; i++)
            code_plan[i] = 16'h0000;
        code_plan[0] = {8'h00, 4'h1, 4'd1};
        code_plan[1] = {8'h02, 4'h2, 4'd2};
        load_config(pnd_pkg::LEN_RESET);
        send_request(8'h20, 1'b1);
        send_request(8'hC0, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'hFF, 1'b0);
    endtask

    // Random tables and stop lengths, each driven by a few restarted byte streams
    task automatic test_random_streams();
        int          start_count;
        int          msg_len;
        logic [15:0] len;
        start_count = requests_decoded;
        while (requests_decoded - start_count < RANDOM_REQUESTS) begin
            settle();
            tables_tried++;
            no_gaps = ($urandom_range(3, 0) == 0);
            plan_random_code($urandom_range(5, 0) == 0);
            case ($urandom_range(5, 0))
                0:       len = 16'd1;
                1:       len = 16'hFFFF;
                2:       len = 16'($urandom);
                default: len = 16'($urandom_range(24, 2));
            endcase
            load_config(len);
            for (int msg = 0; msg < 4; msg++) begin
                // now and then drain everything before the next stream
                if ($urandom_range(7, 0) == 0)
                    settle();
                else if ($urandom_range(3, 0) == 0)
                    no_gaps = !no_gaps;
                msg_len = $urandom_range(40, 1);
                send_request(8'($urandom), 1'b1);
                for (int k = 1; k < msg_len && !stopped; k++)
                    send_request(8'($urandom), $urandom_range(24, 0) == 0);
                if (stopped && $urandom_range(2, 0) == 0)
                    send_request(8'($urandom), 1'b0);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_byte   = '0;
        i_restart   = 1'b0;
        i_out_stall = 1'b0;
        no_gaps     = 1'b0;
        for (int w = 0; w < pnd_pkg::TABLE_WORDS; w++)
            code_words[w] = '0;
        stop_len = pnd_pkg::LEN_RESET;
        clear_decoder();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_table();
        test_invalid_entries();
        test_fixed_codes();
        test_zero_length();
        test_mixed_lengths();
        test_single_bit_codes();
        test_incomplete_code();
        test_random_streams();
        settle();

        $display("Covered %0d requests (%0d decoded) over %0d random code tables.",
                 requests_sent, requests_decoded, tables_tried);
        $display("Checked %0d output bytes, %0d of them errors and %0d end-of-run.",
                 results_seen, error_results, last_results);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
